### hw/rtl/http_response_header_parser_defines.svh
// Assertion macros shared by the HTTP response header parser RTL.
// Needs clk_i and rst_ni in the scope of the file that uses them.
`ifndef HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_PARSER_DEFINES_SVH

// Checked property, masked while reset is asserted
`define HRHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked property that also holds during reset
`define HRHP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### hw/rtl/hrhp_pkg.sv
// Types, codes and character classes of the HTTP response header parser.
// No dependencies; used by http_response_header_parser.
`timescale 1ns / 1ps

package hrhp_pkg;

  // Parser states
  typedef enum logic [3:0] {
    ST_FIRST_START = 4'd0,
    ST_FIRST_LINE  = 4'd1,
    ST_LF_FIRST    = 4'd2,
    ST_LINE_START  = 4'd3,
    ST_FOLD_WS     = 4'd4,
    ST_NAME        = 4'd5,
    ST_COLON_SP    = 4'd6,
    ST_VALUE       = 4'd7,
    ST_LF_HEADER   = 4'd8,
    ST_LF_FINAL    = 4'd9
  } parse_state_e;

  // Status codes
  localparam logic [1:0] STAT_MORE  = 2'd0;
  localparam logic [1:0] STAT_DONE  = 2'd1;
  localparam logic [1:0] STAT_ERROR = 2'd2;

  // Byte roles
  localparam logic [1:0] ROLE_DROP  = 2'd0;
  localparam logic [1:0] ROLE_FIRST = 2'd1;
  localparam logic [1:0] ROLE_NAME  = 2'd2;
  localparam logic [1:0] ROLE_VALUE = 2'd3;

  // Characters
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_LAST_CTRL = 8'd31;
  localparam logic [7:0] CH_DEL   = 8'd127;

  // Result word, status in the lowest bits
  typedef struct packed {
    logic [2:0] pad;
    logic       header_start;
    logic [1:0] byte_role;
    logic [1:0] status;
  } result_t;

  // 0..31 and DEL; high bytes are not controls
  function automatic logic is_control(input logic [7:0] c);
    return (c <= CH_LAST_CTRL) || (c == CH_DEL);
  endfunction

  function automatic logic is_separator(input logic [7:0] c);
    logic sep;
    case (c) inside
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
      "/", "[", "]", "?", "=", "{", "}", " ", "\t": sep = 1'b1;
      default: sep = 1'b0;
    endcase
    return sep;
  endfunction

  // Token: 7-bit, not control, not separator
  function automatic logic is_token(input logic [7:0] c);
    return !c[7] && !is_control(c) && !is_separator(c);
  endfunction

endpackage

### hw/rtl/http_response_header_parser.sv
// Byte-serial HTTP response header parser: state machine and stream ports.
// Depends on hrhp_pkg and http_response_header_parser_defines.svh.
`timescale 1ns / 1ps
`include "http_response_header_parser_defines.svh"

// Takes one byte of an HTTP response per clock on the slave stream and
// returns one 8-bit result per byte on the master stream: parse status,
// the role of the byte (first line, header name, header value or dropped)
// and a flag for the first byte of each header entry. A byte is captured
// into an input register, judged against the parser state and written
// to the output register, so a new byte is taken every clock while the
// output side keeps up; the loop through the state register sets that
// rate. On a parse error the state holds, so the next byte is judged by
// the same state. The parser keeps no text; the caller collects bytes
// using the roles.

module http_response_header_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Slave stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  // Master stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [1:0] status, [3:2] byte_role,
                                     // [4] header_start, [7:5] zero
);

  logic                  in_valid_q, in_valid_d;
  logic [7:0]            in_byte_q;
  logic                  out_valid_q, out_valid_d;
  hrhp_pkg::result_t     out_q, out_d;
  hrhp_pkg::parse_state_e state_q, state_d;
  logic                  header_seen_q, header_seen_d;
  logic                  out_ready;
  logic                  advance;
  logic                  is_ctrl, is_tok, is_ws;

  // Handshake between the two register stages
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;
  assign in_valid_d    = (s_axis_tvalid && s_axis_tready) || (in_valid_q && !out_ready);
  assign out_valid_d   = advance || (out_valid_q && !m_axis_tready);

  // Character classes of the registered byte
  assign is_ctrl = hrhp_pkg::is_control(in_byte_q);
  assign is_tok  = hrhp_pkg::is_token(in_byte_q);
  assign is_ws   = (in_byte_q == hrhp_pkg::CH_SPACE) || (in_byte_q == hrhp_pkg::CH_TAB);

  // Next state; errors leave the state as it is
  always_comb begin
    state_d       = state_q;
    header_seen_d = header_seen_q;
    unique case (state_q)
      hrhp_pkg::ST_FIRST_START: begin
        if (is_tok) state_d = hrhp_pkg::ST_FIRST_LINE;
      end
      hrhp_pkg::ST_FIRST_LINE: begin
        if (in_byte_q == hrhp_pkg::CH_CR) state_d = hrhp_pkg::ST_LF_FIRST;
      end
      hrhp_pkg::ST_LF_FIRST: begin
        if (in_byte_q == hrhp_pkg::CH_LF) state_d = hrhp_pkg::ST_LINE_START;
      end
      hrhp_pkg::ST_LINE_START: begin
        if (in_byte_q == hrhp_pkg::CH_CR) begin
          state_d = hrhp_pkg::ST_LF_FINAL;
        end else if (header_seen_q && is_ws) begin
          state_d = hrhp_pkg::ST_FOLD_WS;
        end else if (is_tok) begin
          state_d       = hrhp_pkg::ST_NAME;
          header_seen_d = 1'b1;
        end
      end
      hrhp_pkg::ST_FOLD_WS: begin
        if (in_byte_q == hrhp_pkg::CH_CR) begin
          state_d = hrhp_pkg::ST_LF_HEADER;
        end else if (!is_ws && !is_ctrl) begin
          state_d = hrhp_pkg::ST_VALUE;
        end
      end
      hrhp_pkg::ST_NAME: begin
        if (in_byte_q == hrhp_pkg::CH_COLON) state_d = hrhp_pkg::ST_COLON_SP;
      end
      hrhp_pkg::ST_COLON_SP: begin
        if (in_byte_q == hrhp_pkg::CH_SPACE) state_d = hrhp_pkg::ST_VALUE;
      end
      hrhp_pkg::ST_VALUE: begin
        if (in_byte_q == hrhp_pkg::CH_CR) state_d = hrhp_pkg::ST_LF_HEADER;
      end
      hrhp_pkg::ST_LF_HEADER: begin
        if (in_byte_q == hrhp_pkg::CH_LF) state_d = hrhp_pkg::ST_LINE_START;
      end
      hrhp_pkg::ST_LF_FINAL: begin
        state_d = hrhp_pkg::ST_LF_FINAL;
      end
      default: begin
        state_d = state_q;
      end
    endcase
  end

  // Result of the registered byte
  always_comb begin
    out_d              = '0;
    out_d.status       = hrhp_pkg::STAT_MORE;
    out_d.byte_role    = hrhp_pkg::ROLE_DROP;
    out_d.header_start = 1'b0;
    unique case (state_q) inside
      hrhp_pkg::ST_FIRST_START: begin
        if (is_tok) out_d.byte_role = hrhp_pkg::ROLE_FIRST;
        else        out_d.status    = hrhp_pkg::STAT_ERROR;
      end
      hrhp_pkg::ST_FIRST_LINE: begin
        if (in_byte_q != hrhp_pkg::CH_CR) out_d.byte_role = hrhp_pkg::ROLE_FIRST;
      end
      hrhp_pkg::ST_LF_FIRST, hrhp_pkg::ST_LF_HEADER: begin
        if (in_byte_q != hrhp_pkg::CH_LF) out_d.status = hrhp_pkg::STAT_ERROR;
      end
      hrhp_pkg::ST_LINE_START: begin
        if (in_byte_q == hrhp_pkg::CH_CR || (header_seen_q && is_ws)) begin
          out_d.status = hrhp_pkg::STAT_MORE;
        end else if (is_tok) begin
          out_d.byte_role    = hrhp_pkg::ROLE_NAME;
          out_d.header_start = 1'b1;
        end else begin
          out_d.status = hrhp_pkg::STAT_ERROR;
        end
      end
      hrhp_pkg::ST_FOLD_WS: begin
        if (in_byte_q == hrhp_pkg::CH_CR || is_ws) begin
          out_d.status = hrhp_pkg::STAT_MORE;
        end else if (is_ctrl) begin
          out_d.status = hrhp_pkg::STAT_ERROR;
        end else begin
          out_d.byte_role = hrhp_pkg::ROLE_VALUE;
        end
      end
      hrhp_pkg::ST_NAME: begin
        if (in_byte_q == hrhp_pkg::CH_COLON) out_d.status    = hrhp_pkg::STAT_MORE;
        else if (is_tok)                     out_d.byte_role = hrhp_pkg::ROLE_NAME;
        else                                 out_d.status    = hrhp_pkg::STAT_ERROR;
      end
      hrhp_pkg::ST_COLON_SP: begin
        if (in_byte_q != hrhp_pkg::CH_SPACE) out_d.status = hrhp_pkg::STAT_ERROR;
      end
      hrhp_pkg::ST_VALUE: begin
        if (in_byte_q == hrhp_pkg::CH_CR) out_d.status    = hrhp_pkg::STAT_MORE;
        else if (is_ctrl)                 out_d.status    = hrhp_pkg::STAT_ERROR;
        else                              out_d.byte_role = hrhp_pkg::ROLE_VALUE;
      end
      hrhp_pkg::ST_LF_FINAL: begin
        if (in_byte_q == hrhp_pkg::CH_LF) out_d.status = hrhp_pkg::STAT_DONE;
        else                              out_d.status = hrhp_pkg::STAT_ERROR;
      end
      default: begin
        out_d.status = hrhp_pkg::STAT_ERROR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q       <= hrhp_pkg::ST_FIRST_START;
      header_seen_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q       <= state_d;
        header_seen_q <= header_seen_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) in_byte_q <= s_axis_tdata;
    if (advance)                        out_q     <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Checks
  `HRHP_ASSERT(a_err_drops, m_axis_tvalid && (out_q.status == hrhp_pkg::STAT_ERROR) |-> (out_q.byte_role == hrhp_pkg::ROLE_DROP) && !out_q.header_start, "error result carries a role")
  `HRHP_ASSERT(a_hstart_name, m_axis_tvalid && out_q.header_start |-> (out_q.byte_role == hrhp_pkg::ROLE_NAME) && header_seen_q, "header start without name role")
  `HRHP_ASSERT(a_err_holds, advance && (out_d.status == hrhp_pkg::STAT_ERROR) |=> (state_q == $past(state_q)) && (header_seen_q == $past(header_seen_q)), "state moved on error")
  `HRHP_ASSERT(a_pad_zero, !m_axis_tvalid || (out_q.pad == 3'd0), "result padding not zero")

endmodule
